FILE: design/lsr_pkg.sv
package lsr_pkg;

    // Slot array geometry and field widths
    localparam int SLOTS      = 32;
    localparam int ID_BITS    = 7;
    localparam int COUNT_BITS = 16;
    localparam int AGE_BITS   = 16;

    localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LIM_BITS = $clog2(SLOTS + 1);

    // Fixed port widths
    localparam int CFG_BITS       = 6;
    localparam int OUT_ID_BITS    = 7;
    localparam int OUT_IDX_BITS   = 5;
    localparam int OUT_COUNT_BITS = 16;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(20);

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic [ID_BITS-1:0]  id;         // id of the vote being handled
        logic [LIM_BITS-1:0] filled;     // filled slots before this vote
        logic [LIM_BITS-1:0] limit;      // slots the policy may fill
        logic                upd;        // apply the vote this cycle
        logic                load;       // write a new entry at load_slot
        logic [IDX_BITS-1:0] load_slot;
        logic [LIM_BITS-1:0] age_lim;    // slots below this age by one tick
    } t_cell_cmd;

    // Running victim word passed from cell to cell
    typedef struct packed {
        logic                  go;
        logic [IDX_BITS-1:0]   index;
        logic [ID_BITS-1:0]    id;
        logic [COUNT_BITS-1:0] count;
        logic [AGE_BITS-1:0]   age;
    } t_scan;

    // What a cell shows the controller for the hit search
    typedef struct packed {
        logic                  match;
        logic [COUNT_BITS-1:0] count;
    } t_cell_view;

    // Cap a count to the result field width
    function automatic logic [OUT_COUNT_BITS-1:0] cap_count(
        input logic [COUNT_BITS-1:0] c
    );
        logic [OUT_COUNT_BITS-1:0] r;
        if (32'(c) > 32'((64'd1 << OUT_COUNT_BITS) - 64'd1)) begin
            r = '1;
        end else begin
            r = OUT_COUNT_BITS'(c);
        end
        return r;
    endfunction

endpackage

FILE: design/lfu_slot_replacement_unit.sv
// Vote in, one result word out per vote; the receiver cannot stall results.
// Hit or free slot: the vote is held in S_LOOK and the result word is registered
// as S_LOOK resolves; the next vote is taken at the edge that ends the strobe,
// so no new vote is taken before the last result is out. Eviction: the victim
// search ripples through the SLOTS cells one cell a cycle, registered in each.
// Reset (synchronous, active low): limit 20, counts, ages and fill count zero.
module lfu_slot_replacement_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lsr_pkg::OUT_ID_BITS-1:0]      i_candidate_id,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lsr_pkg::CFG_BITS-1:0]         i_cfg_data,
    output logic                                 o_result_strobe,
    output logic                                 o_hit,
    output logic [lsr_pkg::OUT_IDX_BITS-1:0]     o_slot_index,
    output logic                                 o_evicted_valid,
    output logic [lsr_pkg::OUT_ID_BITS-1:0]      o_evicted_id,
    output logic [lsr_pkg::OUT_COUNT_BITS-1:0]   o_vote_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN
    } t_state;

    t_state                         r_state;
    logic [lsr_pkg::CFG_BITS-1:0]   r_slots_in_use;
    logic [lsr_pkg::LIM_BITS-1:0]   r_filled;
    logic [lsr_pkg::ID_BITS-1:0]    r_id;

    logic [lsr_pkg::LIM_BITS-1:0]   w_limit;
    logic                           w_free;
    logic                           w_hit;
    logic [lsr_pkg::IDX_BITS-1:0]   w_hit_idx;
    logic [lsr_pkg::COUNT_BITS-1:0] w_hit_count;
    logic [lsr_pkg::COUNT_BITS-1:0] w_hit_next;
    logic [lsr_pkg::SLOTS-1:0]      w_match;
    lsr_pkg::t_cell_cmd             w_cmd;
    lsr_pkg::t_scan                 w_scan [lsr_pkg::SLOTS+1];
    lsr_pkg::t_cell_view            w_view [lsr_pkg::SLOTS];
    lsr_pkg::t_scan                 w_scan_out;
    logic                           w_launch;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= lsr_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slots_in_use <= i_cfg_data;
        end
    end

    // Effective limit: zero acts as one, above SLOTS acts as SLOTS
    always_comb begin
        if (r_slots_in_use == '0) begin
            w_limit = lsr_pkg::LIM_BITS'(1);
        end else if (32'(r_slots_in_use) > 32'(lsr_pkg::SLOTS)) begin
            w_limit = lsr_pkg::LIM_BITS'(lsr_pkg::SLOTS);
        end else begin
            w_limit = lsr_pkg::LIM_BITS'(r_slots_in_use);
        end
    end

    assign w_free = r_filled < w_limit;

    // Row of slot cells
    for (genvar k = 0; k < lsr_pkg::SLOTS; k++) begin : g_cell
        lsr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (lsr_pkg::IDX_BITS'(k)),
            .i_cmd   (w_cmd),
            .i_scan  (w_scan[k]),
            .o_scan  (w_scan[k+1]),
            .o_view  (w_view[k])
        );
    end

    assign w_scan_out = w_scan[lsr_pkg::SLOTS];

    // Victim search enters the first cell when launched
    always_comb begin
        w_scan[0]    = '0;
        w_scan[0].go = w_launch;
    end

    // Hit reduction; at most one filled slot holds a given id
    always_comb begin
        w_hit_idx   = '0;
        w_hit_count = '0;
        for (int k = 0; k < lsr_pkg::SLOTS; k++) begin
            w_match[k] = w_view[k].match;
            if (w_view[k].match) begin
                w_hit_idx   = w_hit_idx | lsr_pkg::IDX_BITS'(k);
                w_hit_count = w_hit_count | w_view[k].count;
            end
        end
        w_hit      = |w_match;
        w_hit_next = (w_hit_count == '1) ? w_hit_count : w_hit_count + 1'b1;
    end

    // Cell command for the current state
    always_comb begin
        w_cmd.id        = r_id;
        w_cmd.filled    = r_filled;
        w_cmd.limit     = w_limit;
        w_cmd.upd       = 1'b0;
        w_cmd.load      = 1'b0;
        w_cmd.load_slot = lsr_pkg::IDX_BITS'(r_filled);
        w_cmd.age_lim   = r_filled;
        w_launch        = 1'b0;
        case (r_state)
            S_LOOK: begin
                if (w_hit) begin
                    w_cmd.upd = 1'b1;
                end else if (w_free) begin
                    w_cmd.upd     = 1'b1;
                    w_cmd.load    = 1'b1;
                    w_cmd.age_lim = r_filled + 1'b1;
                end else begin
                    w_launch = 1'b1;
                end
            end
            S_SCAN: begin
                if (w_scan_out.go) begin
                    w_cmd.upd       = 1'b1;
                    w_cmd.load      = 1'b1;
                    w_cmd.load_slot = w_scan_out.index;
                end
            end
            default: begin
            end
        endcase
    end

    // Controller state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_filled        <= '0;
            o_result_strobe <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    o_result_strobe <= 1'b0;
                    if (start) begin
                        r_id    <= lsr_pkg::ID_BITS'(i_candidate_id);
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (w_hit) begin
                        o_result_strobe <= 1'b1;
                        o_hit           <= 1'b1;
                        o_slot_index    <= lsr_pkg::OUT_IDX_BITS'(w_hit_idx);
                        o_evicted_valid <= 1'b0;
                        o_evicted_id    <= '0;
                        o_vote_count    <= lsr_pkg::cap_count(w_hit_next);
                        r_state         <= S_IDLE;
                    end else if (w_free) begin
                        o_result_strobe <= 1'b1;
                        o_hit           <= 1'b0;
                        o_slot_index    <= lsr_pkg::OUT_IDX_BITS'(r_filled);
                        o_evicted_valid <= 1'b0;
                        o_evicted_id    <= '0;
                        o_vote_count    <= lsr_pkg::OUT_COUNT_BITS'(1);
                        r_filled        <= r_filled + 1'b1;
                        r_state         <= S_IDLE;
                    end else begin
                        o_result_strobe <= 1'b0;
                        r_state         <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_scan_out.go) begin
                        o_result_strobe <= 1'b1;
                        o_hit           <= 1'b0;
                        o_slot_index    <= lsr_pkg::OUT_IDX_BITS'(w_scan_out.index);
                        o_evicted_valid <= 1'b1;
                        o_evicted_id    <= lsr_pkg::OUT_ID_BITS'(w_scan_out.id);
                        o_vote_count    <= lsr_pkg::OUT_COUNT_BITS'(1);
                        r_state         <= S_IDLE;
                    end else begin
                        o_result_strobe <= 1'b0;
                    end
                end
                default: begin
                    o_result_strobe <= 1'b0;
                    r_state         <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Ids held in filled slots are unique
    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one slot matches the vote id");

    // A search word only leaves the row while the controller waits for it
    a_scan_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_out.go |-> (r_state == S_SCAN))
        else $error("victim word left the row outside the search");

    // Every result closes a busy period
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> ($past(busy) && !busy))
        else $error("result without a vote in progress");

    // Eviction and hit exclude each other; a new entry starts at count one
    a_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_hit) |-> (o_vote_count == lsr_pkg::OUT_COUNT_BITS'(1)))
        else $error("new entry does not start at count one");

    // The fill count never passes the slot count
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_filled) <= 32'(lsr_pkg::SLOTS))
        else $error("fill count beyond slot count");
`endif

endmodule

FILE: design/lsr_cell.sv
module lsr_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lsr_pkg::IDX_BITS-1:0]   i_index,
    input  lsr_pkg::t_cell_cmd             i_cmd,
    input  lsr_pkg::t_scan                 i_scan,
    output lsr_pkg::t_scan                 o_scan,
    output lsr_pkg::t_cell_view            o_view
);

    logic [lsr_pkg::ID_BITS-1:0]    r_id;
    logic [lsr_pkg::COUNT_BITS-1:0] r_count;
    logic [lsr_pkg::AGE_BITS-1:0]   r_age;
    lsr_pkg::t_scan                 r_scan;
    lsr_pkg::t_scan                 n_scan;

    logic w_in_use;
    logic w_match;
    logic w_in_limit;
    logic w_aging;
    logic w_loading;
    logic w_take_own;

    // Slot occupancy and hit compare
    assign w_in_use   = lsr_pkg::LIM_BITS'(i_index) < i_cmd.filled;
    assign w_match    = w_in_use && (r_id == i_cmd.id);
    assign w_in_limit = lsr_pkg::LIM_BITS'(i_index) < i_cmd.limit;
    assign w_aging    = lsr_pkg::LIM_BITS'(i_index) < i_cmd.age_lim;
    assign w_loading  = i_cmd.upd && i_cmd.load && (i_index == i_cmd.load_slot);

    assign o_view.match = w_match;
    assign o_view.count = r_count;

    // Victim compare: lower count wins, then older; ties keep the earlier slot
    always_comb begin
        w_take_own = i_scan.go && w_in_limit &&
                     ((i_index == '0) || (r_count < i_scan.count) ||
                      ((r_count == i_scan.count) && (r_age > i_scan.age)));
        n_scan = i_scan;
        if (w_take_own) begin
            n_scan.go    = 1'b1;
            n_scan.index = i_index;
            n_scan.id    = r_id;
            n_scan.count = r_count;
            n_scan.age   = r_age;
        end
    end

    // Count, age and victim word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_age   <= '0;
            r_scan  <= '0;
        end else begin
            r_scan <= n_scan;
            if (w_loading) begin
                r_count <= lsr_pkg::COUNT_BITS'(1);
                r_age   <= lsr_pkg::AGE_BITS'(1);
            end else if (i_cmd.upd) begin
                if (w_aging && (r_age != '1)) begin
                    r_age <= r_age + 1'b1;
                end
                if (w_match && (r_count != '1)) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Id store, written only on load
    always_ff @(posedge i_clk) begin
        if (w_loading) begin
            r_id <= i_cmd.id;
        end
    end

    assign o_scan = r_scan;

endmodule
